// ----- hdl/sck_pkg.sv -----
// types, character codes and helpers shared by the sentence checksum checker
`timescale 1ns / 1ps
`default_nettype none

package sck_pkg;

   localparam logic [7:0] STAR_CHAR     = 8'h2A;
   localparam logic [7:0] ZERO_CHAR     = 8'h30;
   localparam logic [1:0] HEX_CHARS_MAX = 2'd2;

   typedef enum logic [2:0] {
      PH_START = 3'b001,
      PH_BODY  = 3'b010,
      PH_AFTER = 3'b100
   } phase_type;

   typedef struct packed {
      logic       sentence_ok;
      logic [7:0] computed_sum;
      logic [7:0] received_sum;
      logic       star_seen;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_digit(input logic [7:0] c);
      hex_digit_type d;
      d.valid = 1'b1;
      d.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.value = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         // letters a-f / A-F: low nibble 1..6 maps to 10..15
         d.value = c[3:0] + 4'd9;
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/sck_parser.sv -----
// per-sentence parse state, running xor and hex field decode
`timescale 1ns / 1ps
`default_nettype none

module sck_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        data_byte,
   input  wire logic              last_byte,
   output logic                   result_push,
   output sck_pkg::result_type    result
);
   import sck_pkg::*;

   phase_type     phase_ff, phase_in, phase_nx;
   logic [7:0]    xor_ff, xor_in, xor_nx;
   logic [1:0]    count_ff, count_in, count_nx;
   logic [7:0]    hex_ff, hex_in, hex_nx;
   logic          ended_ff, ended_in, ended_nx;
   logic          zeros_ff, zeros_in, zeros_nx;
   hex_digit_type digit;
   logic          star;

   assign digit = hex_digit(data_byte);

   always_comb begin
      phase_nx = phase_ff;
      xor_nx   = xor_ff;
      count_nx = count_ff;
      hex_nx   = hex_ff;
      ended_nx = ended_ff;
      zeros_nx = zeros_ff;
      unique case (phase_ff)
         PH_START: begin
            phase_nx = PH_BODY;
         end
         PH_BODY: begin
            if (data_byte == STAR_CHAR) begin
               phase_nx = PH_AFTER;
            end else begin
               xor_nx = xor_ff ^ data_byte;
            end
         end
         PH_AFTER: begin
            if (count_ff < HEX_CHARS_MAX) begin
               count_nx = count_ff + 2'd1;
               if (data_byte != ZERO_CHAR) begin
                  zeros_nx = 1'b0;
               end
               if (!ended_ff) begin
                  if (digit.valid) begin
                     hex_nx = {hex_ff[3:0], digit.value};
                  end else begin
                     ended_nx = 1'b1;
                  end
               end
            end
         end
         default: begin
            phase_nx = PH_START;
         end
      endcase
   end

   // result is formed from the state after this byte
   always_comb begin
      star = (phase_nx == PH_AFTER);
      result.sentence_ok  = star && (count_nx != 2'd0) &&
                            ((count_nx == HEX_CHARS_MAX && zeros_nx) || (hex_nx == xor_nx));
      result.computed_sum = xor_nx;
      result.received_sum = hex_nx;
      result.star_seen    = star;
   end

   assign result_push = accept && last_byte;

   always_comb begin
      phase_in = phase_ff;
      xor_in   = xor_ff;
      count_in = count_ff;
      hex_in   = hex_ff;
      ended_in = ended_ff;
      zeros_in = zeros_ff;
      if (accept) begin
         if (last_byte) begin
            phase_in = PH_START;
            xor_in   = 8'd0;
            count_in = 2'd0;
            hex_in   = 8'd0;
            ended_in = 1'b0;
            zeros_in = 1'b1;
         end else begin
            phase_in = phase_nx;
            xor_in   = xor_nx;
            count_in = count_nx;
            hex_in   = hex_nx;
            ended_in = ended_nx;
            zeros_in = zeros_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         xor_ff   <= 8'd0;
         count_ff <= 2'd0;
         hex_ff   <= 8'd0;
         ended_ff <= 1'b0;
         zeros_ff <= 1'b1;
      end else begin
         phase_ff <= phase_in;
         xor_ff   <= xor_in;
         count_ff <= count_in;
         hex_ff   <= hex_in;
         ended_ff <= ended_in;
         zeros_ff <= zeros_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/sck_out_buf.sv -----
// result register with one skid entry
`timescale 1ns / 1ps
`default_nettype none

module sck_out_buf (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire sck_pkg::result_type push_data,
   output logic                   full,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sck_pkg::result_type    rsp_data
);
   import sck_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop = main_valid_ff && !rsp_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // input side is stalled while the skid entry is occupied
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

endmodule

`default_nettype wire

// ----- hdl/sentence_checksum_check_top.sv -----
// top level of the sentence checksum checker
// takes one sentence character per transfer on the req_ channel, the final character
// flagged by req_last_byte. the first character (start marker) is skipped, the rest up
// to the first '*' are xored, and up to two characters after the '*' are decoded as a
// hex value (either case, a non-hex character ends it). one rsp_ transfer follows each
// final character: sentence_ok is set when a star was found, at least one character
// follows it, and the characters are "00" or the value equals the xor. a character is
// taken every cycle unless req_stall is high; the verdict is formed from the parse state
// and the final character and captured by the output register, or by the skid entry while
// that register is held. a two-entry output buffer lets input keep flowing while a result
// waits, and req_stall rises only when both entries are held
`timescale 1ns / 1ps
`default_nettype none

module sentence_checksum_check_top (
   input  wire logic       clock,
   input  wire logic       reset,
   // input character channel
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   // result channel
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_sentence_ok,
   output logic [7:0]      rsp_computed_sum,
   output logic [7:0]      rsp_received_sum,
   output logic            rsp_star_seen
);
   import sck_pkg::*;

   logic       accept;
   logic       result_push;
   logic       buf_full;
   result_type result;
   result_type rsp_data;

   // a transfer on the input side
   assign accept    = req_valid && !req_stall;
   assign req_stall = buf_full;

   sck_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .last_byte   (req_last_byte),
      .result_push (result_push),
      .result      (result)
   );

   // output register plus skid entry
   sck_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_sentence_ok  = rsp_data.sentence_ok;
   assign rsp_computed_sum = rsp_data.computed_sum;
   assign rsp_received_sum = rsp_data.received_sum;
   assign rsp_star_seen    = rsp_data.star_seen;

endmodule

`default_nettype wire
